/* hdl/bounded_deque_with_index_read_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the bounded deque
// Shared concurrent assertion forms, clocked on clk.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_DEQUE_WITH_INDEX_READ_TOP_MACROS_SVH
`define BOUNDED_DEQUE_WITH_INDEX_READ_TOP_MACROS_SVH

// Check a property outside reset.
`define BDQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property at every edge, reset included.
`define BDQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hdl/bdq_pkg.sv */
// ----------------------------------------------------------------------------
// bdq_pkg
// Types, constants and ring arithmetic for the bounded deque.
// ----------------------------------------------------------------------------
package bdq_pkg;

  localparam int CAPACITY = 256;
  localparam int ELEM_W   = 32;
  localparam int PTR_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // field widths of the stream items
  localparam int CMD_W   = 3;
  localparam int DATA_W  = 32;
  localparam int IDX_W   = 8;
  localparam int ECNT_W  = 9;
  localparam int STAT_W  = 2;
  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 48;
  localparam int S_TUSER_W = 3;
  localparam int M_TUSER_W = 3;
  localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_HEAD = 3'd0,
    CMD_INS_TAIL = 3'd1,
    CMD_RM_HEAD  = 3'd2,
    CMD_RM_TAIL  = 3'd3,
    CMD_RD_HEAD  = 3'd4,
    CMD_RD_TAIL  = 3'd5,
    CMD_RD_INDEX = 3'd6
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_RANGE = 2'd3
  } stat_t;

  typedef enum logic {
    S_IDLE,
    S_READ
  } ctl_state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;       // input transaction taken this cycle
    logic load_direct;  // load result computed without the store
    logic load_ram;     // load result from store read data
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic             needs_read;  // current command is a read that succeeds
    logic [CNT_W-1:0] count;
  } dp_sts_t;

  // position a + b modulo CAPACITY, both operands below CAPACITY
  function automatic logic [PTR_W-1:0] ring_add(logic [PTR_W-1:0] a, logic [PTR_W-1:0] b);
    logic [PTR_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= (PTR_W+1)'(CAPACITY)) begin
      sum = sum - (PTR_W+1)'(CAPACITY);
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

/* hdl/bdq_ram.sv */
// ----------------------------------------------------------------------------
// bdq_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/bdq_ctrl.sv */
// ----------------------------------------------------------------------------
// bdq_ctrl
// Handshake controller: accepts commands, sequences store reads.
// ----------------------------------------------------------------------------
module bdq_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  output logic             m_tvalid,
  input  logic             m_tready,
  input  bdq_pkg::dp_sts_t sts,
  output bdq_pkg::dp_cmd_t cmd
);

  bdq_pkg::ctl_state_t state, state_next;
  logic                out_valid, out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bdq_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next      = state;
    s_tready        = 1'b0;
    cmd.accept      = 1'b0;
    cmd.load_direct = 1'b0;
    cmd.load_ram    = 1'b0;
    unique case (state)
      bdq_pkg::S_IDLE: begin
        // hold off commands while reset is applied
        s_tready   = !rst && (!out_valid || m_tready);
        cmd.accept = s_tvalid && s_tready;
        if (cmd.accept) begin
          if (sts.needs_read) begin
            state_next = bdq_pkg::S_READ;
          end else begin
            cmd.load_direct = 1'b1;
          end
        end
      end
      bdq_pkg::S_READ: begin
        cmd.load_ram = 1'b1;
        state_next   = bdq_pkg::S_IDLE;
      end
      default: begin
        state_next = bdq_pkg::S_IDLE;
      end
    endcase
    if (cmd.load_direct || cmd.load_ram) begin
      out_valid_next = 1'b1;
    end else if (m_tready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  assign m_tvalid = out_valid;

endmodule

/* hdl/bdq_dpath.sv */
// ----------------------------------------------------------------------------
// bdq_dpath
// Head pointer, count, element store and result register.
// ----------------------------------------------------------------------------
module bdq_dpath (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [bdq_pkg::S_TDATA_W-1:0]   s_tdata,
  input  logic [bdq_pkg::S_TUSER_W-1:0]   s_tuser,
  output logic [bdq_pkg::M_TDATA_W-1:0]   m_tdata,
  output logic [bdq_pkg::M_TUSER_W-1:0]   m_tuser,
  input  bdq_pkg::dp_cmd_t                cmd,
  output bdq_pkg::dp_sts_t                sts
);

  logic [bdq_pkg::PTR_W-1:0]  head, head_next;
  logic [bdq_pkg::CNT_W-1:0]  count, count_next;

  logic [bdq_pkg::DATA_W-1:0] read_data;
  logic                       read_valid;
  logic [bdq_pkg::CNT_W-1:0]  res_count;
  bdq_pkg::stat_t             res_status;

  bdq_pkg::cmd_t              op;
  logic [bdq_pkg::DATA_W-1:0] element_data;
  logic [bdq_pkg::IDX_W-1:0]  read_index;
  logic                       full, empty, idx_out;
  logic                       ok, is_read, we;
  bdq_pkg::stat_t             status;
  logic [bdq_pkg::PTR_W-1:0]  addr, head_dec, cnt_low, tail_off;
  logic [bdq_pkg::ELEM_W-1:0] rdata;

  assign op           = bdq_pkg::cmd_t'(s_tuser[bdq_pkg::CMD_W-1:0]);
  assign element_data = s_tdata[bdq_pkg::DATA_W-1:0];
  assign read_index   = s_tdata[bdq_pkg::DATA_W +: bdq_pkg::IDX_W];

  assign full     = (count == bdq_pkg::CNT_W'(bdq_pkg::CAPACITY));
  assign empty    = (count == '0);
  assign idx_out  = (bdq_pkg::CMP_W'(read_index) >= bdq_pkg::CMP_W'(count));
  assign cnt_low  = count[bdq_pkg::PTR_W-1:0];
  assign tail_off = cnt_low - 1'b1;
  assign head_dec = (head == '0) ? bdq_pkg::PTR_W'(bdq_pkg::CAPACITY - 1) : head - 1'b1;

  always_comb begin
    status     = bdq_pkg::STAT_OK;
    is_read    = 1'b0;
    addr       = head;
    head_next  = head;
    count_next = count;
    case (op)
      bdq_pkg::CMD_INS_HEAD: begin
        addr = head_dec;
        if (full) begin
          status = bdq_pkg::STAT_FULL;
        end else begin
          head_next  = head_dec;
          count_next = count + 1'b1;
        end
      end
      bdq_pkg::CMD_INS_TAIL: begin
        addr = bdq_pkg::ring_add(head, cnt_low);
        if (full) begin
          status = bdq_pkg::STAT_FULL;
        end else begin
          count_next = count + 1'b1;
        end
      end
      bdq_pkg::CMD_RM_HEAD: begin
        if (empty) begin
          status = bdq_pkg::STAT_EMPTY;
        end else begin
          head_next  = bdq_pkg::ring_add(head, bdq_pkg::PTR_W'(1));
          count_next = count - 1'b1;
        end
      end
      bdq_pkg::CMD_RM_TAIL: begin
        if (empty) begin
          status = bdq_pkg::STAT_EMPTY;
        end else begin
          count_next = count - 1'b1;
        end
      end
      bdq_pkg::CMD_RD_HEAD: begin
        is_read = 1'b1;
        if (empty) status = bdq_pkg::STAT_EMPTY;
      end
      bdq_pkg::CMD_RD_TAIL: begin
        is_read = 1'b1;
        addr    = bdq_pkg::ring_add(head, tail_off);
        if (empty) status = bdq_pkg::STAT_EMPTY;
      end
      bdq_pkg::CMD_RD_INDEX: begin
        is_read = 1'b1;
        addr    = bdq_pkg::ring_add(head, bdq_pkg::PTR_W'(read_index));
        if (empty) begin
          status = bdq_pkg::STAT_EMPTY;
        end else if (idx_out) begin
          status = bdq_pkg::STAT_RANGE;
        end
      end
      default: begin
        // unused code: no operation
      end
    endcase
  end

  assign ok = (status == bdq_pkg::STAT_OK);
  assign we = cmd.accept && ok &&
              (op == bdq_pkg::CMD_INS_HEAD || op == bdq_pkg::CMD_INS_TAIL);

  assign sts.needs_read = is_read && ok;
  assign sts.count      = count;

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else if (cmd.accept) begin
      head  <= head_next;
      count <= count_next;
    end
  end

  bdq_ram #(
    .WIDTH (bdq_pkg::ELEM_W),
    .DEPTH (bdq_pkg::CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (addr),
    .wdata (bdq_pkg::ELEM_W'(element_data)),
    .raddr (addr),
    .rdata (rdata)
  );

  // result register; count does not move during a store read
  always_ff @(posedge clk) begin
    if (cmd.load_direct) begin
      read_data  <= '0;
      read_valid <= 1'b0;
      res_count  <= count_next;
      res_status <= status;
    end else if (cmd.load_ram) begin
      read_data  <= bdq_pkg::DATA_W'(rdata);
      read_valid <= 1'b1;
      res_count  <= count;
      res_status <= bdq_pkg::STAT_OK;
    end
  end

  assign m_tdata = {(bdq_pkg::M_TDATA_W - bdq_pkg::DATA_W - bdq_pkg::ECNT_W)'(0),
                    bdq_pkg::ECNT_W'(res_count), read_data};
  assign m_tuser = {res_status, read_valid};

endmodule

/* hdl/bounded_deque_with_index_read_top.sv */
// ----------------------------------------------------------------------------
// bounded_deque_with_index_read_top
// Fixed-capacity double-ended queue of position words with indexed read.
// ----------------------------------------------------------------------------
// Usage
//   Commands arrive on the s_ stream, one per transaction, with the opcode in
//   s_tuser. Each command yields exactly one result transaction on the m_
//   stream, in command order: read data, a valid flag, the count after the
//   command and a status code (full, empty or index out of range).
//   Flow: inserts, removes and refused commands load the result register at
//   the accepting edge and run at one per cycle while m_tready stays high.
//   A successful read first passes through S_READ, since the element store has
//   a registered read port; no command is taken until its result is loaded.
//   The store lives in a ring addressed by a head pointer, so no command
//   moves any element.
//   Reset clears the head pointer, the count and both handshakes; the store
//   contents are left as they are, since no entry is read before written.
//   When the receiver stalls, the result register holds its transaction and
//   s_tready drops until that result is taken; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`include "bounded_deque_with_index_read_top_macros.svh"

module bounded_deque_with_index_read_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // s_tdata, from bit 0: element_data[31:0], read_index[39:32]
  input  logic [bdq_pkg::S_TDATA_W-1:0] s_tdata,
  // s_tuser, from bit 0: command[2:0]
  input  logic [bdq_pkg::S_TUSER_W-1:0] s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // m_tdata, from bit 0: read_data[31:0], entry_count[40:32], zero fill
  output logic [bdq_pkg::M_TDATA_W-1:0] m_tdata,
  // m_tuser, from bit 0: read_valid[0], status[2:1]
  output logic [bdq_pkg::M_TUSER_W-1:0] m_tuser
);

  bdq_pkg::dp_cmd_t dp_cmd;
  bdq_pkg::dp_sts_t dp_sts;

  // sequence handshakes and store reads
  bdq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (dp_sts),
    .cmd      (dp_cmd)
  );

  // hold ring state, store and result
  bdq_dpath u_dpath (
    .clk     (clk),
    .rst     (rst),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .cmd     (dp_cmd),
    .sts     (dp_sts)
  );

  // a successful read must be followed by its store result
  `BDQ_ASSERT(a_read_follows, dp_cmd.accept && dp_sts.needs_read |=> dp_cmd.load_ram, "read result not loaded")
  // no new command while a store read is outstanding
  `BDQ_ASSERT(a_no_accept_busy, dp_cmd.load_ram |-> !s_tready, "command accepted during store read")
  // count never exceeds the capacity
  `BDQ_ASSERT(a_count_bound, dp_sts.count <= bdq_pkg::CNT_W'(bdq_pkg::CAPACITY), "count past capacity")
  // reset drops m_tvalid and clears the count
  `BDQ_ASSERT_ALWAYS(a_reset_idle, rst |=> !m_tvalid && dp_sts.count == '0, "state not cleared by reset")

endmodule
